### hw/rtl/b64e_pkg.sv
// Shared types and constants for the base64 encoder with a loadable alphabet.
package b64e_pkg;

  localparam int NumWords = 8;
  localparam int WordW    = 64;
  localparam int CharW    = 8;
  localparam int SymW     = 6;
  localparam int CfgIdxW  = 4;
  localparam int WordSelW = $clog2(NumWords);
  localparam int LaneSelW = SymW - WordSelW;
  localparam int MaxChars = 4;
  localparam int SlotSelW = $clog2(MaxChars);

  localparam logic [CharW-1:0] PadChar = 8'h3D;

  // Bytes already taken in the current 3-byte group.
  localparam logic [1:0] PosFirst  = 2'd0;
  localparam logic [1:0] PosSecond = 2'd1;
  localparam logic [1:0] PosThird  = 2'd2;

  typedef struct packed {
    logic [CharW-1:0] data_byte;
    logic             last_byte;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             last_char;
  } out_item_t;

  typedef struct packed {
    logic [SymW-1:0] idx;
    logic            pad;
  } sym_slot_t;

  // Characters produced by one input item; cnt is the index of the final slot.
  typedef struct packed {
    logic                         valid;
    sym_slot_t [MaxChars-1:0]     slot;
    logic [SlotSelW-1:0]          cnt;
    logic                         fin;
  } bundle_t;

endpackage

### hw/rtl/b64e_alphabet.sv
// Alphabet register file and symbol lookup.
module b64e_alphabet
  import b64e_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [WordW-1:0]   wr_data,
  input  logic [SymW-1:0]    rd_idx,
  output logic [CharW-1:0]   rd_char
);

  logic [NumWords-1:0][WordW-1:0] words;
  logic [WordW-1:0]               word_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      words <= '0;
    end else if (wr_en && (wr_index < CfgIdxW'(NumWords))) begin
      words[wr_index[WordSelW-1:0]] <= wr_data;
    end
  end

  assign word_sel = words[rd_idx[SymW-1:LaneSelW]];
  assign rd_char  = word_sel[{rd_idx[LaneSelW-1:0], 3'b000} +: CharW];

endmodule

### hw/rtl/b64e_pack.sv
// Input stage: group position tracking and splitting of each byte into symbol slots.
module b64e_pack
  import b64e_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     bnd_done,
  output bundle_t  bnd
);

  logic [3:0]               leftover;
  logic [1:0]               pos;
  logic [3:0]               leftover_next;
  logic [1:0]               pos_next;
  logic                     bnd_valid;
  sym_slot_t [MaxChars-1:0] slot;
  sym_slot_t [MaxChars-1:0] slot_next;
  logic [SlotSelW-1:0]      cnt;
  logic [SlotSelW-1:0]      cnt_next;
  logic                     fin;
  logic                     accept;
  logic [CharW-1:0]         b;

  assign b        = in_item.data_byte;
  assign in_stall = bnd_valid && !bnd_done;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    slot_next     = '0;
    cnt_next      = '0;
    leftover_next = '0;
    pos_next      = PosFirst;
    case (pos)
      PosSecond: begin
        slot_next[0].idx = {leftover[1:0], b[7:4]};
        if (in_item.last_byte) begin
          slot_next[1].idx = {b[3:0], 2'b00};
          slot_next[2].pad = 1'b1;
          cnt_next         = 2'd2;
        end else begin
          leftover_next = b[3:0];
          pos_next      = PosThird;
        end
      end
      PosThird: begin
        slot_next[0].idx = {leftover, b[7:6]};
        slot_next[1].idx = b[5:0];
        cnt_next         = 2'd1;
      end
      default: begin
        // An unused position code is handled as the start of a group.
        slot_next[0].idx = b[7:2];
        if (in_item.last_byte) begin
          slot_next[1].idx = {b[1:0], 4'b0000};
          slot_next[2].pad = 1'b1;
          slot_next[3].pad = 1'b1;
          cnt_next         = 2'd3;
        end else begin
          leftover_next = {2'b00, b[1:0]};
          pos_next      = PosSecond;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover  <= '0;
      pos       <= PosFirst;
      bnd_valid <= 1'b0;
    end else begin
      if (accept) begin
        leftover  <= leftover_next;
        pos       <= pos_next;
        bnd_valid <= 1'b1;
      end else if (bnd_done) begin
        bnd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot <= slot_next;
      cnt  <= cnt_next;
      fin  <= in_item.last_byte;
    end
  end

  assign bnd.valid = bnd_valid;
  assign bnd.slot  = slot;
  assign bnd.cnt   = cnt;
  assign bnd.fin   = fin;

endmodule

### hw/rtl/b64e_serial.sv
// Output stage: sends the slots of a bundle one character per cycle while the output is not stalled.
module b64e_serial
  import b64e_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  bundle_t           bnd,
  output logic              bnd_done,
  output logic [SymW-1:0]   rd_idx,
  input  logic [CharW-1:0]  rd_char,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item
);

  logic [SlotSelW-1:0] ptr;
  logic                advance;
  logic                at_end;
  sym_slot_t           cur;

  assign cur      = bnd.slot[ptr];
  assign rd_idx   = cur.idx;
  assign at_end   = (ptr == bnd.cnt);
  assign advance  = bnd.valid && (!out_valid || !out_stall);
  assign bnd_done = advance && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        ptr       <= at_end ? '0 : ptr + 1'b1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.out_char  <= cur.pad ? PadChar : rd_char;
      out_item.last_char <= bnd.fin && at_end;
    end
  end

endmodule

### hw/rtl/base64_encoder_custom_alphabet_core.sv
// Streaming base64 encoder with an alphabet loaded through eight 64-bit registers.
// Path: an accepted byte is registered as a bundle in the input stage, and its characters are
// then registered one by one in the output register of the output stage.
// Throughput: one character per cycle while the output is not stalled; a byte yields 1 or 2
// characters, up to 4 on the final byte, so a full group of three bytes yields four characters.
// The next byte is accepted in the cycle that the previous byte's last character is registered.
// Synchronous reset clears the alphabet to zero, the group position and leftover bits.
module base64_encoder_custom_alphabet_core
  import b64e_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [WordW-1:0]   cfg_data
);

  bundle_t          bnd;
  logic             bnd_done;
  logic [SymW-1:0]  rd_idx;
  logic [CharW-1:0] rd_char;

  assign cfg_ready = 1'b1;

  b64e_alphabet u_alphabet (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .rd_idx   (rd_idx),
    .rd_char  (rd_char)
  );

  b64e_pack u_pack (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .bnd_done (bnd_done),
    .bnd      (bnd)
  );

  b64e_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .bnd       (bnd),
    .bnd_done  (bnd_done),
    .rd_idx    (rd_idx),
    .rd_char   (rd_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // An accepted item always leaves a bundle waiting for the output stage.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> bnd.valid)
    else $error("accepted item left no bundle");

  // Only a bundle that is present can be finished.
  assert property (@(posedge clk) disable iff (rst)
    bnd_done |-> bnd.valid)
    else $error("bundle finished while none held");

  // Four characters come only from the final byte of a message.
  assert property (@(posedge clk) disable iff (rst)
    (bnd.valid && (bnd.cnt == 2'd3)) |-> bnd.fin)
    else $error("four characters from a non-final byte");

  // Finishing a final bundle puts a marked last character in the output register.
  assert property (@(posedge clk) disable iff (rst)
    (bnd_done && bnd.fin) |=> (out_valid && out_item.last_char))
    else $error("final character not marked");

endmodule

### dv/base64_encoder_custom_alphabet_core_tb.sv
// Self-checking testbench for the base64 encoder core with a loadable alphabet.
`timescale 1ns / 1ps

module base64_encoder_custom_alphabet_core_tb;
  import b64e_pkg::*;

  localparam int ClkPeriod = 12;
  localparam int RstCycles = 6;
  localparam int NumCfgIdx = 1 << CfgIdxW;
  localparam int PhaseBytes = 20;
  // Worst case is far below this: under 200 bytes, 4 chars each, heavy output stalls.
  localparam int LimitCycles = 200000;

  localparam logic [CfgIdxW-1:0] AlphabetWord0 = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [WordW-1:0] cfg_data = '0;

  base64_encoder_custom_alphabet_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Encoder state as the block should hold it.
  logic [WordW-1:0] alpha_words [NumWords];
  logic [WordW-1:0] alphabet_plan [NumWords];
  logic [3:0] enc_leftover = '0;
  logic [1:0] enc_group_pos = PosFirst;

  in_item_t pending_bytes [$];
  out_item_t expected_chars [$];
  int mismatch_count = 0;
  int bytes_taken = 0;

  initial begin
    for (int w = 0; w < NumWords; w++) begin
      alpha_words[w] = '0;
    end
  end

  function automatic logic [CharW-1:0] alphabet_char(input logic [SymW-1:0] sym);
    return alpha_words[sym[5:3]][sym[2:0]*8 +: 8];
  endfunction

  function automatic void add_char(input logic [CharW-1:0] c, input logic fin);
    out_item_t ch;
    ch.out_char = c;
    ch.last_char = fin;
    expected_chars.push_back(ch);
  endfunction

  // Works out the characters one accepted byte produces and advances the group state.
  task automatic encode_byte(input in_item_t it);
    logic [7:0] b;
    b = it.data_byte;
    case (enc_group_pos)
      PosSecond: begin
        add_char(alphabet_char({enc_leftover[1:0], b[7:4]}), 1'b0);
        if (it.last_byte) begin
          add_char(alphabet_char({b[3:0], 2'b00}), 1'b0);
          add_char(PadChar, 1'b1);
          enc_leftover = '0;
          enc_group_pos = PosFirst;
        end else begin
          enc_leftover = b[3:0];
          enc_group_pos = PosThird;
        end
      end
      PosThird: begin
        add_char(alphabet_char({enc_leftover, b[7:6]}), 1'b0);
        add_char(alphabet_char(b[5:0]), it.last_byte);
        enc_leftover = '0;
        enc_group_pos = PosFirst;
      end
      default: begin
        // Leftover bits from an earlier group are not used at a group start.
        add_char(alphabet_char(b[7:2]), 1'b0);
        if (it.last_byte) begin
          add_char(alphabet_char({b[1:0], 4'b0000}), 1'b0);
          add_char(PadChar, 1'b0);
          add_char(PadChar, 1'b1);
          enc_leftover = '0;
          enc_group_pos = PosFirst;
        end else begin
          enc_leftover = {2'b00, b[1:0]};
          enc_group_pos = PosSecond;
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] ERROR: %s", $time, msg);
  endtask

  // Byte driver: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        encode_byte(in_item);
        void'(pending_bytes.pop_front());
        bytes_taken <= bytes_taken + 1;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_valid <= 1'b1;
        in_item <= pending_bytes[0];
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall: a pattern that changes every segment, plus long hold-offs
  // at fixed byte counts so that the block backs up into its input.
  int hold_cycles = 0;
  int next_hold_at = 30;
  int seg_left = 0;
  int stall_mode = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (bytes_taken >= next_hold_at) begin
      hold_cycles = 63;
      next_hold_at += 50;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        stall_mode = $urandom_range(0, 3);
      end
      seg_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin : check_chars
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h last %b",
                                  out_item.out_char, out_item.last_char));
      end else begin
        want = expected_chars.pop_front();
        if (out_item.out_char !== want.out_char) begin
          report_mismatch($sformatf("out_char %h, expected %h",
                                    out_item.out_char, want.out_char));
        end
        if (out_item.last_char !== want.last_char) begin
          report_mismatch($sformatf("last_char %b, expected %b (char %h)",
                                    out_item.last_char, want.last_char, want.out_char));
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < NumWords) begin
      alpha_words[idx] = value;
    end
  endtask

  task automatic load_alphabet();
    for (int w = 0; w < NumWords; w++) begin
      write_reg(AlphabetWord0 + CfgIdxW'(w), alphabet_plan[w]);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_bytes.size() != 0 || expected_chars.size() != 0);
  endtask

  // Queues whole messages of random length until at least n bytes are pending.
  task automatic queue_random_messages(input int n);
    int queued;
    int len;
    in_item_t it;
    queued = 0;
    while (queued < n) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 9);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 7))
          0: it.data_byte = 8'h00;
          1: it.data_byte = 8'hFF;
          default: it.data_byte = 8'($urandom);
        endcase
        it.last_byte = (k == len - 1);
        pending_bytes.push_back(it);
      end
      queued += len;
    end
  endtask

  initial begin
    string std_alpha;
    logic [7:0] pats [10];
    in_item_t it;
    int n;

    std_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    pats = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFC, 8'h03, 8'hF0, 8'h0F, 8'h80, 8'h01};

    repeat (RstCycles) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 64; i++) begin
      alphabet_plan[i / 8][(i % 8) * 8 +: 8] = std_alpha[i];
    end
    load_alphabet();
    // Writes beyond the last alphabet word must leave the alphabet alone.
    for (int i = NumWords; i < NumCfgIdx; i++) begin
      write_reg(CfgIdxW'(i), {$urandom, $urandom});
    end

    // Directed messages of 1 to 6 bytes: every group position ends a message.
    n = 0;
    for (int len = 1; len <= 6; len++) begin
      for (int k = 0; k < len; k++) begin
        it.data_byte = pats[n % 10];
        it.last_byte = (k == len - 1);
        pending_bytes.push_back(it);
        n++;
      end
    end
    wait_drained();

    for (int w = 0; w < NumWords; w++) alphabet_plan[w] = '1;
    load_alphabet();
    queue_random_messages(PhaseBytes);
    wait_drained();

    for (int w = 0; w < NumWords; w++) alphabet_plan[w] = '0;
    load_alphabet();
    queue_random_messages(PhaseBytes);
    wait_drained();

    for (int w = 0; w < NumWords; w++) alphabet_plan[w] = {$urandom, $urandom};
    load_alphabet();
    queue_random_messages(PhaseBytes);
    wait_drained();

    // Standard alphabet with one word of pad characters and repeated symbols.
    for (int i = 0; i < 64; i++) begin
      alphabet_plan[i / 8][(i % 8) * 8 +: 8] = std_alpha[i];
    end
    alphabet_plan[$urandom_range(0, NumWords - 1)] = {8{PadChar}};
    load_alphabet();
    queue_random_messages(PhaseBytes);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(LimitCycles * ClkPeriod);
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_alphabet.sv
hw/rtl/b64e_pack.sv
hw/rtl/b64e_serial.sv
hw/rtl/base64_encoder_custom_alphabet_core.sv
dv/base64_encoder_custom_alphabet_core_tb.sv
